>>> rtl/isf_pkg.sv
// shared constants and types for the 1-d ising spin flip step block
// no dependencies; imported by the interfaces, the spin ram user and the top level
package isf_pkg;

   localparam int LATTICE_SITES = 1024;
   localparam int PROB_BITS     = 16;

   localparam int SITE_W        = 10;
   localparam int DRAW_W        = 16;
   localparam int PROB_W        = PROB_BITS + 1;
   localparam int MAG_W         = 12;
   localparam int CNT_W         = 32;
   localparam int SPIN_ADDR_W   = $clog2(LATTICE_SITES);

   localparam int NUM_PROB_REGS = 6;
   localparam int REG_IDX_W     = 3;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_UP_NEG  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_UP_ZERO = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_UP_POS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DN_NEG  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DN_ZERO = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DN_POS  = 3'd5;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRIAL = 1'b1;

   typedef logic [PROB_W-1:0]      prob_type;
   typedef logic [CNT_W-1:0]       count_type;
   typedef logic [SPIN_ADDR_W-1:0] spin_addr_type;

   localparam prob_type ONE_PROB = prob_type'(1) << PROB_BITS;

endpackage

>>> rtl/isf_chan_if.sv
// valid/ready channel interfaces for the spin flip step block
// depends on isf_pkg for the payload widths
interface isf_req_if import isf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [SITE_W-1:0] site;
   logic              spin_value;
   logic [DRAW_W-1:0] random_draw;

   modport source (output valid, opcode, site, spin_value, random_draw, input ready);
   modport sink   (input valid, opcode, site, spin_value, random_draw, output ready);
endinterface

interface isf_rsp_if import isf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    accepted;
   logic [SITE_W-1:0]       site_echo;
   logic                    spin_after;
   logic signed [MAG_W-1:0] magnetization;
   logic [CNT_W-1:0]        trial_index;
   logic [CNT_W-1:0]        accept_count;
   logic [CNT_W-1:0]        reject_count;
   logic [PROB_W-1:0]       trial_probability;

   modport source (output valid, accepted, site_echo, spin_after, magnetization,
                   trial_index, accept_count, reject_count, trial_probability,
                   input ready);
   modport sink   (input valid, accepted, site_echo, spin_after, magnetization,
                   trial_index, accept_count, reject_count, trial_probability,
                   output ready);
endinterface

>>> rtl/ising_1d_spin_flip_step.sv
// top level of the 1-d ising single-spin-flip step block
// depends on isf_pkg, isf_req_if / isf_rsp_if and isf_ram
//
// usage
//   req_chan carries one beat per item: opcode (write a spin or run a flip
//   trial), site, spin_value and random_draw. rsp_chan returns exactly one
//   beat per item with the step's outcome, the magnetization and counters.
//   csr_* is an apb-style port for the six acceptance probability registers
//   (byte address 4*i, 17 bits each, 65536 means one); pready is tied high.
// sequence
//   a flip trial goes S_IDLE (accept), S_RDL, S_RDR, S_EXEC (result load);
//   a spin write skips S_RDR, an out-of-range site goes straight to S_EXEC.
//   the spin ram has one read port, so the three spins of a trial (site,
//   left, right) are read one per cycle; new items wait for S_IDLE.
// reset
//   synchronous, active high. afterwards a clearing pass writes spin -1 to
//   all LATTICE_SITES ram entries with req_chan.ready low; config writes
//   are taken during the pass.
// stall
//   a new item is taken while a finished result waits in the output
//   register; the item then holds in its last step until rsp_chan is free.
module ising_1d_spin_flip_step import isf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   isf_req_if.sink               req_chan,
   isf_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // sequencer codes
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RDL   = 3'd2;
   localparam logic [2:0] S_RDR   = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;

   localparam spin_addr_type LAST_SITE = spin_addr_type'(LATTICE_SITES - 1);

   logic [2:0]    state_ff, state_in;
   spin_addr_type clr_ff, clr_in;

   // item held for the duration of the step
   logic              op_ff;
   logic [SITE_W-1:0] site_ff;
   logic              spin_val_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic              range_ff;
   logic              center_ff;
   logic              left_ff;

   prob_type  prob_ff [NUM_PROB_REGS];
   logic signed [MAG_W-1:0] sum_ff, sum_in;
   count_type trial_ff, trial_in;
   count_type acc_ff, acc_in;
   count_type rej_ff, rej_in;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_acc_ff;
   logic [SITE_W-1:0]       rsp_site_ff;
   logic                    rsp_spin_ff;
   logic signed [MAG_W-1:0] rsp_mag_ff;
   count_type               rsp_index_ff;
   count_type               rsp_acc_cnt_ff;
   count_type               rsp_rej_cnt_ff;
   prob_type                rsp_prob_ff;

   logic          req_ready;
   logic          req_fire;
   logic          exec_fire;
   logic          rsp_free;
   spin_addr_type site_addr, left_addr, right_addr;
   spin_addr_type rd_addr, wr_addr;
   logic          wr_en, wr_data, rd_data;

   logic                 is_trial;
   logic [REG_IDX_W-1:0] prob_sel;
   prob_type             prob_used;
   logic                 flip;
   logic                 new_spin;
   logic                 spin_after;
   logic                 accepted;

   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;

   //----------------------------------------------------------------------
   // config registers
   //----------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[REG_IDX_W+1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PROB_REGS; i++) begin
            prob_ff[i] <= ONE_PROB;
         end
      end else if (csr_wr && (int'(csr_idx) < NUM_PROB_REGS)) begin
         prob_ff[csr_idx] <= csr_pwdata[PROB_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (int'(csr_idx) < NUM_PROB_REGS) begin
         csr_prdata = CSR_DATA_W'(prob_ff[csr_idx]);
      end
   end

   //----------------------------------------------------------------------
   // spin memory, ring neighbor addresses
   //----------------------------------------------------------------------
   assign site_addr  = spin_addr_type'(site_ff);
   assign left_addr  = (site_addr == '0) ? LAST_SITE : site_addr - 1'b1;
   assign right_addr = (site_addr == LAST_SITE) ? '0 : site_addr + 1'b1;

   // center is read at the accept edge, then left, then right (held in exec)
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = spin_addr_type'(req_chan.site);
         S_RDL:   rd_addr = left_addr;
         default: rd_addr = right_addr;
      endcase
   end

   isf_ram #(
      .WIDTH (1),
      .DEPTH (LATTICE_SITES)
   ) u_spin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   //----------------------------------------------------------------------
   // handshakes
   //----------------------------------------------------------------------
   assign req_ready      = (state_ff == S_IDLE);
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid & req_ready;
   assign rsp_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign exec_fire      = (state_ff == S_EXEC) & rsp_free;

   //----------------------------------------------------------------------
   // trial evaluation (valid in exec; rd_data holds the right neighbor)
   //----------------------------------------------------------------------
   assign is_trial = (op_ff == OP_TRIAL);

   always_comb begin
      if (center_ff) begin
         case ({left_ff, rd_data})
            2'b00:   prob_sel = REG_UP_NEG;
            2'b11:   prob_sel = REG_UP_POS;
            default: prob_sel = REG_UP_ZERO;
         endcase
      end else begin
         case ({left_ff, rd_data})
            2'b00:   prob_sel = REG_DN_NEG;
            2'b11:   prob_sel = REG_DN_POS;
            default: prob_sel = REG_DN_ZERO;
         endcase
      end
   end

   assign prob_used = prob_ff[prob_sel];
   // strict compare, so a probability above one always flips
   assign flip      = prob_used > {1'b0, draw_ff};
   assign new_spin  = is_trial ? (center_ff ^ flip) : spin_val_ff;
   assign accepted  = range_ff & is_trial & flip;
   assign spin_after = range_ff & new_spin;

   // the clearing pass and the exec step share the single write port
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = 1'b0;
      end else begin
         wr_en   = exec_fire & range_ff;
         wr_addr = site_addr;
         wr_data = new_spin;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      trial_in = trial_ff;
      acc_in   = acc_ff;
      rej_in   = rej_ff;
      if (range_ff) begin
         if (new_spin != center_ff) begin
            sum_in = new_spin ? sum_ff + MAG_W'(2) : sum_ff - MAG_W'(2);
         end
         if (is_trial) begin
            // counters stop at all ones
            if (trial_ff != '1) begin
               trial_in = trial_ff + 1'b1;
            end
            if (flip) begin
               if (acc_ff != '1) begin
                  acc_in = acc_ff + 1'b1;
               end
            end else if (rej_ff != '1) begin
               rej_in = rej_ff + 1'b1;
            end
         end
      end
   end

   //----------------------------------------------------------------------
   // sequencer
   //----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SITE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               // an out-of-range site reads nothing
               if (int'(req_chan.site) < LATTICE_SITES) begin
                  state_in = S_RDL;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_RDL: begin
            state_in = is_trial ? S_RDR : S_EXEC;
         end
         S_RDR: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         sum_ff   <= MAG_W'(-LATTICE_SITES);
         trial_ff <= '0;
         acc_ff   <= '0;
         rej_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (exec_fire) begin
            sum_ff   <= sum_in;
            trial_ff <= trial_in;
            acc_ff   <= acc_in;
            rej_ff   <= rej_in;
         end
      end
   end

   // item capture and spin capture (payload, no reset)
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_chan.opcode;
         site_ff     <= req_chan.site;
         spin_val_ff <= req_chan.spin_value;
         draw_ff     <= req_chan.random_draw;
         range_ff    <= (int'(req_chan.site) < LATTICE_SITES);
      end
      if (state_ff == S_RDL) begin
         center_ff <= rd_data;
      end
      if (state_ff == S_RDR) begin
         left_ff <= rd_data;
      end
   end

   //----------------------------------------------------------------------
   // result register
   //----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_acc_ff     <= accepted;
         rsp_site_ff    <= site_ff;
         rsp_spin_ff    <= spin_after;
         rsp_mag_ff     <= sum_in;
         rsp_index_ff   <= trial_ff;
         rsp_acc_cnt_ff <= acc_in;
         rsp_rej_cnt_ff <= rej_in;
         rsp_prob_ff    <= (range_ff && is_trial) ? prob_used : '0;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.accepted          = rsp_acc_ff;
   assign rsp_chan.site_echo         = rsp_site_ff;
   assign rsp_chan.spin_after        = rsp_spin_ff;
   assign rsp_chan.magnetization     = rsp_mag_ff;
   assign rsp_chan.trial_index       = rsp_index_ff;
   assign rsp_chan.accept_count      = rsp_acc_cnt_ff;
   assign rsp_chan.reject_count      = rsp_rej_cnt_ff;
   assign rsp_chan.trial_probability = rsp_prob_ff;

   //----------------------------------------------------------------------
   // assertions
   //----------------------------------------------------------------------
`ifndef SYNTHESIS
   // every trial is either accepted or rejected while nothing saturates
   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      (trial_ff != '1) |-> (({1'b0, acc_ff} + {1'b0, rej_ff}) == {1'b0, trial_ff}))
      else $error("accept and reject counts do not add up to trial count");

   // the spin sum keeps the parity of the lattice size
   a_sum_parity: assert property (@(posedge clock) disable iff (reset)
      sum_ff[0] == 1'(LATTICE_SITES % 2))
      else $error("spin sum has wrong parity");

   // a result only appears out of the exec step
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result beat raised outside exec step");
`endif

endmodule

>>> rtl/isf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module isf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the 1-d ising single-spin-flip step block
// depends on isf_pkg, isf_req_if / isf_rsp_if and ising_1d_spin_flip_step
module testbench;
   import isf_pkg::*;

   // one result beat as the block should present it
   typedef struct {
      logic                    accepted;
      logic [SITE_W-1:0]       site_echo;
      logic                    spin_after;
      logic signed [MAG_W-1:0] magnetization;
      count_type               trial_index;
      count_type               accept_count;
      count_type               reject_count;
      prob_type                trial_probability;
   } flip_outcome_type;

   logic clock;
   logic reset;

   isf_req_if req_chan_if ();
   isf_rsp_if rsp_chan_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ising_1d_spin_flip_step u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan_if),
      .rsp_chan    (rsp_chan_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // lattice model: spins, running sum, counters and the probability table
   logic          spin_lattice [LATTICE_SITES];
   int            spin_total;
   count_type     trials_done;
   count_type     flips_taken;
   count_type     flips_refused;
   prob_type      prob_table [NUM_PROB_REGS];

   flip_outcome_type pending_outcomes [$];
   int               mismatches;
   bit               steady;   // when set neither side idles

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous ceiling for the whole run, reported as a failure
   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   function automatic count_type bump_sat(input count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // advance the lattice model by one item and return the beat it should produce
   function automatic flip_outcome_type flip_step_outcome(input logic op,
                                                          input logic [SITE_W-1:0] site,
                                                          input logic spin_in,
                                                          input logic [DRAW_W-1:0] draw);
      flip_outcome_type     r;
      int                   s;
      int                   left_site;
      int                   right_site;
      int                   nbr;
      logic [REG_IDX_W-1:0] sel;
      s = int'(site);
      r.accepted          = 1'b0;
      r.site_echo         = site;
      r.spin_after        = 1'b0;
      r.trial_index       = trials_done;
      r.trial_probability = '0;
      if (s < LATTICE_SITES) begin
         if (op == OP_WRITE) begin
            if (spin_lattice[s] != spin_in) begin
               spin_total += spin_in ? 2 : -2;
               spin_lattice[s] = spin_in;
            end
         end else begin
            // periodic ring: both ends wrap around
            left_site  = (s == 0) ? LATTICE_SITES - 1 : s - 1;
            right_site = (s == LATTICE_SITES - 1) ? 0 : s + 1;
            nbr = (spin_lattice[left_site] ? 1 : -1) + (spin_lattice[right_site] ? 1 : -1);
            if (spin_lattice[s])
               sel = (nbr < 0) ? REG_UP_NEG : (nbr == 0) ? REG_UP_ZERO : REG_UP_POS;
            else
               sel = (nbr < 0) ? REG_DN_NEG : (nbr == 0) ? REG_DN_ZERO : REG_DN_POS;
            r.trial_probability = prob_table[sel];
            // strict compare; values above one always accept
            if (prob_table[sel] > {1'b0, draw}) begin
               r.accepted = 1'b1;
               spin_total += spin_lattice[s] ? -2 : 2;
               spin_lattice[s] = ~spin_lattice[s];
               flips_taken = bump_sat(flips_taken);
            end else begin
               flips_refused = bump_sat(flips_refused);
            end
            trials_done = bump_sat(trials_done);
         end
         r.spin_after = spin_lattice[s];
      end
      r.magnetization = spin_total[MAG_W-1:0];
      r.accept_count  = flips_taken;
      r.reject_count  = flips_refused;
      return r;
   endfunction

   task automatic check_outcome();
      flip_outcome_type want;
      if (pending_outcomes.size() == 0) begin
         note_mismatch("result beat with nothing pending", 64'd1, 64'd0);
      end else begin
         want = pending_outcomes.pop_front();
         if (rsp_chan_if.accepted !== want.accepted)
            note_mismatch("accepted", rsp_chan_if.accepted, want.accepted);
         if (rsp_chan_if.site_echo !== want.site_echo)
            note_mismatch("site_echo", rsp_chan_if.site_echo, want.site_echo);
         if (rsp_chan_if.spin_after !== want.spin_after)
            note_mismatch("spin_after", rsp_chan_if.spin_after, want.spin_after);
         if (rsp_chan_if.magnetization !== want.magnetization)
            note_mismatch("magnetization", rsp_chan_if.magnetization, want.magnetization);
         if (rsp_chan_if.trial_index !== want.trial_index)
            note_mismatch("trial_index", rsp_chan_if.trial_index, want.trial_index);
         if (rsp_chan_if.accept_count !== want.accept_count)
            note_mismatch("accept_count", rsp_chan_if.accept_count, want.accept_count);
         if (rsp_chan_if.reject_count !== want.reject_count)
            note_mismatch("reject_count", rsp_chan_if.reject_count, want.reject_count);
         if (rsp_chan_if.trial_probability !== want.trial_probability)
            note_mismatch("trial_probability", rsp_chan_if.trial_probability,
                          want.trial_probability);
      end
   endtask

   // one process sees both channels: result beats are checked before the
   // request beat of the same edge updates the model
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan_if.valid && rsp_chan_if.ready)
            check_outcome();
         if (req_chan_if.valid && req_chan_if.ready)
            pending_outcomes.push_back(flip_step_outcome(req_chan_if.opcode,
                                                         req_chan_if.site,
                                                         req_chan_if.spin_value,
                                                         req_chan_if.random_draw));
      end
   end

   // result side back-pressure, about a quarter of the cycles
   always @(negedge clock) begin
      rsp_chan_if.ready <= steady || ($urandom_range(0, 99) >= 24);
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_item(input logic op, input logic [SITE_W-1:0] site,
                            input logic spin_in, input logic [DRAW_W-1:0] draw);
      if (!steady) begin
         while ($urandom_range(0, 99) < 24) begin
            req_chan_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan_if.valid       <= 1'b1;
      req_chan_if.opcode      <= op;
      req_chan_if.site        <= site;
      req_chan_if.spin_value  <= spin_in;
      req_chan_if.random_draw <= draw;
      do @(posedge clock); while (!req_chan_if.ready);
      @(negedge clock);
   endtask

   // drop valid and let every pending beat come back before touching registers
   task automatic settle_block();
      req_chan_if.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input int idx, input prob_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      prob_table[idx] = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_check(input int idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(prob_table[idx]))
         note_mismatch($sformatf("probability register %0d", idx), csr_prdata,
                       prob_table[idx]);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_all_probs(input prob_type value);
      for (int r = 0; r < NUM_PROB_REGS; r++)
         csr_write(r, value);
   endtask

   function automatic prob_type random_prob();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ONE_PROB;
         2:       return '1;
         3:       return prob_type'($urandom_range(65537, 131071));
         default: return prob_type'($urandom_range(0, 65536));
      endcase
   endfunction

   // reset values, then extremes and a distinct pattern, each read back
   task automatic test_register_access();
      for (int r = 0; r < NUM_PROB_REGS; r++)
         csr_read_check(r);
      csr_write(REG_UP_NEG, '0);
      csr_write(REG_UP_ZERO, '1);
      csr_write(REG_UP_POS, 17'h0AAAA);
      csr_write(REG_DN_NEG, 17'h15555);
      csr_write(REG_DN_ZERO, ONE_PROB);
      csr_write(REG_DN_POS, 17'd1);
      for (int r = 0; r < NUM_PROB_REGS; r++)
         csr_read_check(r);
      load_all_probs(ONE_PROB);
   endtask

   // ring ends, draw extremes, zero and over-one probabilities, draw equal to probability
   task automatic test_directed_corners();
      // probability one: any draw below one flips
      send_item(OP_WRITE, 10'd0, 1'b1, 16'h0000);
      send_item(OP_WRITE, 10'h3FF, 1'b1, 16'hFFFF);
      send_item(OP_WRITE, 10'd1, 1'b0, 16'h5555);
      send_item(OP_WRITE, 10'h2AA, 1'b1, 16'hAAAA);
      send_item(OP_WRITE, 10'h155, 1'b1, 16'h0000);
      send_item(OP_WRITE, 10'h155, 1'b0, 16'h0000);
      send_item(OP_TRIAL, 10'd0, 1'b0, 16'hFFFF);
      send_item(OP_TRIAL, 10'h3FF, 1'b1, 16'h0000);
      send_item(OP_TRIAL, 10'h2AA, 1'b0, 16'hAAAA);
      send_item(OP_TRIAL, 10'h155, 1'b1, 16'h5555);
      settle_block();
      // probability zero never flips
      load_all_probs('0);
      send_item(OP_TRIAL, 10'd0, 1'b0, 16'h0000);
      send_item(OP_TRIAL, 10'h3FF, 1'b0, 16'hFFFF);
      send_item(OP_TRIAL, 10'd1, 1'b1, 16'h0000);
      settle_block();
      // above one always flips
      load_all_probs('1);
      send_item(OP_TRIAL, 10'h3FE, 1'b0, 16'hFFFF);
      send_item(OP_TRIAL, 10'd2, 1'b0, 16'hFFFF);
      settle_block();
      // draw equal to the probability is refused, one below is taken
      load_all_probs(prob_type'(40000));
      send_item(OP_TRIAL, 10'd5, 1'b0, 16'd40000);
      send_item(OP_TRIAL, 10'd5, 1'b0, 16'd39999);
      send_item(OP_TRIAL, 10'h3FF, 1'b0, 16'd40000);
      send_item(OP_TRIAL, 10'h3FF, 1'b0, 16'd39999);
      settle_block();
   endtask

   // fill half the ring with up spins back to back: a long run with no idling
   task automatic test_magnetization_sweep();
      steady = 1'b1;
      for (int s = 0; s < LATTICE_SITES / 2; s++)
         send_item(OP_WRITE, SITE_W'(s), 1'b1, DRAW_W'($urandom()));
      settle_block();
      steady = 1'b0;
   endtask

   // mostly bursts of writes and trials inside a small window so all six
   // neighbour cases show up, with a share of fully random beats
   task automatic test_random_trials(input int phases, input int per_phase);
      int                base;
      int                k;
      logic              op;
      logic [SITE_W-1:0] site;
      logic [DRAW_W-1:0] draw;
      for (int p = 0; p < phases; p++) begin
         for (int r = 0; r < NUM_PROB_REGS; r++)
            csr_write(r, random_prob());
         base = 0;
         for (int n = 0; n < per_phase; n++) begin
            if (n % 12 == 0)
               base = $urandom_range(0, LATTICE_SITES - 1);
            draw = DRAW_W'($urandom());
            k = $urandom_range(0, NUM_PROB_REGS - 1);
            if ($urandom_range(0, 7) == 0 && prob_table[k] <= prob_type'(65535))
               draw = prob_table[k][DRAW_W-1:0];
            if ($urandom_range(0, 4) != 0) begin
               site = SITE_W'((base + $urandom_range(0, 5)) % LATTICE_SITES);
               op   = ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_TRIAL;
            end else begin
               site = SITE_W'($urandom());
               op   = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_TRIAL;
            end
            send_item(op, site, 1'($urandom_range(0, 1)), draw);
         end
         settle_block();
      end
   endtask

   initial begin
      mismatches    = 0;
      steady        = 1'b0;
      spin_total    = -LATTICE_SITES;
      trials_done   = '0;
      flips_taken   = '0;
      flips_refused = '0;
      for (int s = 0; s < LATTICE_SITES; s++)
         spin_lattice[s] = 1'b0;
      for (int r = 0; r < NUM_PROB_REGS; r++)
         prob_table[r] = ONE_PROB;

      reset                   <= 1'b1;
      req_chan_if.valid       <= 1'b0;
      req_chan_if.opcode      <= OP_WRITE;
      req_chan_if.site        <= '0;
      req_chan_if.spin_value  <= 1'b0;
      req_chan_if.random_draw <= '0;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= '0;
      csr_pwdata              <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // the clearing pass after reset holds req ready low; beats just wait
      test_register_access();
      test_directed_corners();
      test_magnetization_sweep();
      test_random_trials(5, 100);

      settle_block();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
